>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define GSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define GSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gsc_pkg.sv
`default_nettype none
package gsc_pkg;

  // Register stages of each conversion path, plus the output register.
  localparam int CORE_DEPTH = 11;
  localparam int PIPE_DEPTH = CORE_DEPTH + 1;

  localparam logic [31:0] EPOCH_SHIFT_S = 32'd432000;
  localparam logic [11:0] BASE_YEAR     = 12'd1980;
  localparam logic [10:0] QUAD_DAYS     = 11'd1461;

  // Reciprocals: q = (x * MUL) >> SHIFT is the quotient or one below it.
  localparam logic [30:0] MUL60   = 31'd1145324612;  // 2^34 / 15, x = t >> 2
  localparam logic [18:0] MUL3    = 19'd349525;      // 2^20 / 3,  x = t >> 3
  localparam logic [16:0] MUL1461 = 17'd91867;       // 2^27 / 1461
  localparam logic [16:0] MUL7    = 17'd74898;       // 2^19 / 7

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic [2:0]  weekday;
  } date_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } date_in_t;

  // First day of each year within a four-year set.
  function automatic logic [10:0] yr_start(input logic [1:0] idx);
    logic [10:0] v;
    unique case (idx)
      2'd0:    v = 11'd0;
      2'd1:    v = 11'd366;
      2'd2:    v = 11'd731;
      default: v = 11'd1096;
    endcase
    return v;
  endfunction

  // First day of each month within a year; index 12 is the year length.
  function automatic logic [8:0] mon_start(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = leap ? 9'd60  : 9'd59;
      4'd3:    v = leap ? 9'd91  : 9'd90;
      4'd4:    v = leap ? 9'd121 : 9'd120;
      4'd5:    v = leap ? 9'd152 : 9'd151;
      4'd6:    v = leap ? 9'd182 : 9'd181;
      4'd7:    v = leap ? 9'd213 : 9'd212;
      4'd8:    v = leap ? 9'd244 : 9'd243;
      4'd9:    v = leap ? 9'd274 : 9'd273;
      4'd10:   v = leap ? 9'd305 : 9'd304;
      4'd11:   v = leap ? 9'd335 : 9'd334;
      default: v = leap ? 9'd366 : 9'd365;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/gps_seconds_calendar_convert_top.sv
// Throughput: one beat per cycle in both directions; a stall on the output
// holds the pipeline, and empty stages ahead of it keep accepting input.
// Reset: rst (synchronous, active high) clears the valid bit of every stage;
// the data registers are not reset.
`default_nettype none
module gps_seconds_calendar_convert_top import gsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // in_seconds, in_year, in_month, in_day, in_hour, in_minute, in_sec, 2 zero bits
  input  logic [71:0] s_axis_tdata,
  // cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_seconds, out_year, out_month, out_day, out_hour, out_minute, out_sec,
  // weekday, 7 zero bits
  output logic [79:0] m_axis_tdata
);

  logic [PIPE_DEPTH-1:0] en;
  date_in_t              din;
  date_t                 date;
  logic [31:0]           secs;
  logic                  cmd_d;
  logic [79:0]           out_data;

  assign din.year   = s_axis_tdata[43:32];
  assign din.month  = s_axis_tdata[47:44];
  assign din.day    = s_axis_tdata[52:48];
  assign din.hour   = s_axis_tdata[57:53];
  assign din.minute = s_axis_tdata[63:58];
  assign din.sec    = s_axis_tdata[69:64];

  gsc_ctl u_ctl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .en      (en)
  );

  gsc_s2d u_s2d (
    .clk     (clk),
    .en      (en[CORE_DEPTH-1:0]),
    .seconds (s_axis_tdata[31:0]),
    .date    (date)
  );

  gsc_d2s u_d2s (
    .clk     (clk),
    .en      (en[CORE_DEPTH-1:0]),
    .cmd     (s_axis_tuser),
    .din     (din),
    .cmd_out (cmd_d),
    .seconds (secs)
  );

  // Zero the fields of the direction not asked for.
  always_ff @(posedge clk) begin
    if (en[PIPE_DEPTH-1]) begin
      if (cmd_d) begin
        out_data <= {48'd0, secs};
      end else begin
        out_data <= {7'd0, date.weekday, date.sec, date.minute, date.hour,
                     date.day, date.month, date.year, 32'd0};
      end
    end
  end

  assign m_axis_tdata = out_data;

endmodule
`default_nettype wire

>>> hw/rtl/gsc_ctl.sv
`default_nettype none
module gsc_ctl import gsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [PIPE_DEPTH-1:0] en
);

  logic [PIPE_DEPTH-1:0] vld;

  // A stage loads when it is empty or the stage after it loads too.
  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_ready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_ready = en[0];
  assign m_valid = vld[PIPE_DEPTH-1];

endmodule
`default_nettype wire

>>> hw/rtl/gsc_s2d.sv
`default_nettype none
module gsc_s2d import gsc_pkg::*; (
  input  logic                  clk,
  input  logic [CORE_DEPTH-1:0] en,
  input  logic [31:0]           seconds,
  output date_t                 date
);

  logic [31:0] s1_t;
  logic [31:0] s2_t;
  logic [26:0] s2_q;
  logic [26:0] s3_t;
  logic [5:0]  s3_sec;
  logic [26:0] s4_t;
  logic [20:0] s4_q;
  logic [5:0]  s4_sec;
  logic [20:0] s5_t;
  logic [5:0]  s5_min;
  logic [5:0]  s5_sec;
  logic [20:0] s6_t;
  logic [15:0] s6_q;
  logic [5:0]  s6_min;
  logic [5:0]  s6_sec;
  logic [15:0] s7_days;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_min;
  logic [5:0]  s7_sec;
  logic [15:0] s8_days;
  logic [16:0] s8_dp1;
  logic [5:0]  s8_q;
  logic [4:0]  s8_hour;
  logic [5:0]  s8_min;
  logic [5:0]  s8_sec;
  logic [5:0]  s9_quad;
  logic [10:0] s9_rem;
  logic [16:0] s9_dp1;
  logic [12:0] s9_wq;
  logic [4:0]  s9_hour;
  logic [5:0]  s9_min;
  logic [5:0]  s9_sec;
  logic [11:0] s10_year;
  logic [1:0]  s10_yi;
  logic [8:0]  s10_rem;
  logic [2:0]  s10_wd;
  logic [4:0]  s10_hour;
  logic [5:0]  s10_min;
  logic [5:0]  s10_sec;
  date_t       s11;

  logic [60:0] p2;
  logic [31:0] r3;
  logic [55:0] p4;
  logic [26:0] r5;
  logic [36:0] p6;
  logic [20:0] r7;
  logic [32:0] p8;
  logic [16:0] r9;
  logic [33:0] p9;
  logic [1:0]  yi10;
  logic [16:0] r10;
  logic [3:0]  mi11;
  logic [8:0]  base11;

  always_comb begin
    p2 = 61'(s1_t[31:2]) * 61'(MUL60);
    r3 = s2_t - (32'({s2_q, 6'b0}) - 32'({s2_q, 2'b0}));
    p4 = 56'(s3_t[26:2]) * 56'(MUL60);
    r5 = s4_t - (27'({s4_q, 6'b0}) - 27'({s4_q, 2'b0}));
    p6 = 37'(s5_t[20:3]) * 37'(MUL3);
    r7 = s6_t - (21'({s6_q, 4'b0}) + 21'({s6_q, 3'b0}));
    p8 = 33'(s7_days) * 33'(MUL1461);
    r9 = 17'(s8_days) - 17'(s8_q) * 17'(QUAD_DAYS);
    p9 = 34'(s8_dp1) * 34'(MUL7);

    // Year within the four-year set.
    priority if (s9_rem >= yr_start(2'd3)) begin
      yi10 = 2'd3;
    end else if (s9_rem >= yr_start(2'd2)) begin
      yi10 = 2'd2;
    end else if (s9_rem >= yr_start(2'd1)) begin
      yi10 = 2'd1;
    end else begin
      yi10 = 2'd0;
    end
    r10 = s9_dp1 - 17'({s9_wq, 3'b0}) + 17'(s9_wq);

    // Month: last start that the day of year has reached.
    mi11 = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (9'(s10_rem) >= mon_start(s10_yi == 2'd0, 4'(k))) begin
        mi11 = 4'(k);
      end
    end
    base11 = mon_start(s10_yi == 2'd0, mi11);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_t <= seconds + EPOCH_SHIFT_S;
    end
    if (en[1]) begin
      s2_t <= s1_t;
      s2_q <= p2[60:34];
    end
    if (en[2]) begin
      if (r3[6:0] >= 7'd60) begin
        s3_t   <= s2_q + 27'd1;
        s3_sec <= 6'(r3[6:0] - 7'd60);
      end else begin
        s3_t   <= s2_q;
        s3_sec <= r3[5:0];
      end
    end
    if (en[3]) begin
      s4_t   <= s3_t;
      s4_q   <= p4[54:34];
      s4_sec <= s3_sec;
    end
    if (en[4]) begin
      if (r5[6:0] >= 7'd60) begin
        s5_t   <= s4_q + 21'd1;
        s5_min <= 6'(r5[6:0] - 7'd60);
      end else begin
        s5_t   <= s4_q;
        s5_min <= r5[5:0];
      end
      s5_sec <= s4_sec;
    end
    if (en[5]) begin
      s6_t   <= s5_t;
      s6_q   <= p6[35:20];
      s6_min <= s5_min;
      s6_sec <= s5_sec;
    end
    if (en[6]) begin
      if (r7[5:0] >= 6'd24) begin
        s7_days <= s6_q + 16'd1;
        s7_hour <= 5'(r7[5:0] - 6'd24);
      end else begin
        s7_days <= s6_q;
        s7_hour <= r7[4:0];
      end
      s7_min <= s6_min;
      s7_sec <= s6_sec;
    end
    if (en[7]) begin
      s8_days <= s7_days;
      s8_dp1  <= 17'(s7_days) + 17'd1;
      s8_q    <= p8[32:27];
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_sec  <= s7_sec;
    end
    if (en[8]) begin
      if (r9 >= 17'(QUAD_DAYS)) begin
        s9_quad <= s8_q + 6'd1;
        s9_rem  <= 11'(r9 - 17'(QUAD_DAYS));
      end else begin
        s9_quad <= s8_q;
        s9_rem  <= r9[10:0];
      end
      s9_dp1  <= s8_dp1;
      s9_wq   <= p9[31:19];
      s9_hour <= s8_hour;
      s9_min  <= s8_min;
      s9_sec  <= s8_sec;
    end
    if (en[9]) begin
      // 1461 = 5 mod 7 and the set starts on a Tuesday, so weekday = (days + 1) mod 7.
      s10_year <= BASE_YEAR + 12'({s9_quad, yi10});
      s10_yi   <= yi10;
      s10_rem  <= 9'(s9_rem - yr_start(yi10));
      s10_wd   <= (r10[3:0] >= 4'd7) ? 3'(r10[3:0] - 4'd7) : r10[2:0];
      s10_hour <= s9_hour;
      s10_min  <= s9_min;
      s10_sec  <= s9_sec;
    end
    if (en[10]) begin
      s11.year    <= s10_year;
      s11.month   <= mi11 + 4'd1;
      s11.day     <= 5'(s10_rem - base11 + 9'd1);
      s11.hour    <= s10_hour;
      s11.minute  <= s10_min;
      s11.sec     <= s10_sec;
      s11.weekday <= s10_wd;
    end
  end

  assign date = s11;

endmodule
`default_nettype wire

>>> hw/rtl/gsc_d2s.sv
`default_nettype none
module gsc_d2s import gsc_pkg::*; (
  input  logic                  clk,
  input  logic [CORE_DEPTH-1:0] en,
  input  logic                  cmd,
  input  date_in_t              din,
  output logic                  cmd_out,
  output logic [31:0]           seconds
);

  localparam int PAD = CORE_DEPTH - 7;

  logic signed [10:0] d1_sets;
  logic [1:0]         d1_yi;
  logic [3:0]         d1_mi;
  logic [4:0]         d1_day;
  logic [4:0]         d1_hour;
  logic [5:0]         d1_min;
  logic [5:0]         d1_sec;
  logic               d1_cmd;
  logic [31:0]        d2_mul;
  logic [31:0]        d2_add;
  logic [4:0]         d2_hour;
  logic [5:0]         d2_min;
  logic [5:0]         d2_sec;
  logic               d2_cmd;
  logic [31:0]        d3_t;
  logic [4:0]         d3_hour;
  logic [5:0]         d3_min;
  logic [5:0]         d3_sec;
  logic               d3_cmd;
  logic [31:0]        d4_t;
  logic [5:0]         d4_min;
  logic [5:0]         d4_sec;
  logic               d4_cmd;
  logic [31:0]        d5_t;
  logic [5:0]         d5_sec;
  logic               d5_cmd;
  logic [31:0]        d6_t;
  logic               d6_cmd;
  logic [31:0]        d7_t;
  logic               d7_cmd;
  logic [31:0]        dly_t   [PAD];
  logic               dly_cmd [PAD];

  logic signed [12:0] yd;
  logic signed [12:0] yd_adj;
  logic [3:0]         mi1;
  logic [10:0]        off2;

  localparam logic signed [11:0] QUAD_DAYS_S = 12'sd1461;

  always_comb begin
    yd     = $signed({1'b0, din.year}) - $signed({1'b0, BASE_YEAR});
    // Round the set count toward zero for years before the base year.
    yd_adj = yd[12] ? yd + 13'sd3 : yd;
    mi1    = (din.month == 4'd0) ? 4'd0 : din.month - 4'd1;
    if (mi1 > 4'd12) begin
      mi1 = 4'd12;
    end
    off2 = (d1_yi == 2'd0) ? 11'(mon_start(1'b1, d1_mi))
                           : yr_start(d1_yi) + 11'(mon_start(1'b0, d1_mi));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_sets <= 11'(yd_adj >>> 2);
      d1_yi   <= din.year[1:0];
      d1_mi   <= mi1;
      d1_day  <= din.day;
      d1_hour <= din.hour;
      d1_min  <= din.minute;
      d1_sec  <= din.sec;
      d1_cmd  <= cmd;
    end
    if (en[1]) begin
      d2_mul  <= 32'(d1_sets) * 32'(QUAD_DAYS_S);
      d2_add  <= 32'(off2) + 32'(d1_day) - 32'd1;
      d2_hour <= d1_hour;
      d2_min  <= d1_min;
      d2_sec  <= d1_sec;
      d2_cmd  <= d1_cmd;
    end
    if (en[2]) begin
      d3_t    <= d2_mul + d2_add;
      d3_hour <= d2_hour;
      d3_min  <= d2_min;
      d3_sec  <= d2_sec;
      d3_cmd  <= d2_cmd;
    end
    if (en[3]) begin
      d4_t   <= (d3_t << 4) + (d3_t << 3) + 32'(d3_hour);
      d4_min <= d3_min;
      d4_sec <= d3_sec;
      d4_cmd <= d3_cmd;
    end
    if (en[4]) begin
      d5_t   <= (d4_t << 6) - (d4_t << 2) + 32'(d4_min);
      d5_sec <= d4_sec;
      d5_cmd <= d4_cmd;
    end
    if (en[5]) begin
      d6_t   <= (d5_t << 6) - (d5_t << 2) + 32'(d5_sec);
      d6_cmd <= d5_cmd;
    end
    if (en[6]) begin
      d7_t   <= d6_t - EPOCH_SHIFT_S;
      d7_cmd <= d6_cmd;
    end
    // Delay to line up with the date path.
    if (en[7]) begin
      dly_t[0]   <= d7_t;
      dly_cmd[0] <= d7_cmd;
    end
    for (int i = 1; i < PAD; i++) begin
      if (en[7+i]) begin
        dly_t[i]   <= dly_t[i-1];
        dly_cmd[i] <= dly_cmd[i-1];
      end
    end
  end

  assign seconds = dly_t[PAD-1];
  assign cmd_out = dly_cmd[PAD-1];

endmodule
`default_nettype wire

>>> hw/rtl/gsc_chk.sv
`default_nettype none
`include "assert_macros.svh"
module gsc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [71:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata
);

  `GSC_ASSERT_NXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
  `GSC_ASSERT_NXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data changed while stalled")
  `GSC_ASSERT_IMP(a_ready_when_free, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input refused with a free output")
  `GSC_ASSERT_IMP(a_one_direction, m_axis_tvalid, (m_axis_tdata[31:0] == 32'd0) || (m_axis_tdata[72:32] == 41'd0), "both directions carry data")
  `GSC_ASSERT_IMP(a_field_range, m_axis_tvalid, (m_axis_tdata[47:44] <= 4'd12) && (m_axis_tdata[57:53] <= 5'd23) && (m_axis_tdata[63:58] <= 6'd59) && (m_axis_tdata[69:64] <= 6'd59) && (m_axis_tdata[72:70] <= 3'd6), "date field out of range")

endmodule

bind gps_seconds_calendar_convert_top gsc_chk u_gsc_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> verif/gps_seconds_calendar_convert_checker.sv
`default_nettype none
module gps_seconds_calendar_convert_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // in_seconds, in_year, in_month, in_day, in_hour, in_minute, in_sec, 2 zero bits
  input  logic [71:0] s_axis_tdata,
  // cmd
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_seconds, out_year, out_month, out_day, out_hour, out_minute, out_sec,
  // weekday, 7 zero bits
  input  logic [79:0] m_axis_tdata,
  output int          error_count,
  output int          pending_count
);

  typedef struct packed {
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic [2:0]  weekday;
  } stamp_t;

  stamp_t expected_stamps[$];
  int     mismatch_tally = 0;

  function automatic logic [31:0] month_length(input logic leap, input int m);
    logic [31:0] len;
    case (m)
      2:             len = leap ? 32'd29 : 32'd28;
      4, 6, 9, 11:   len = 32'd30;
      default:       len = 32'd31;
    endcase
    return len;
  endfunction

  // Days before month idx+1; idx 12 gives the year length.
  function automatic logic [31:0] month_offset(input logic leap, input logic [31:0] idx);
    logic [31:0] total;
    int m;
    total = 32'd0;
    for (m = 1; m <= 12; m++)
      if (m <= idx) total = total + month_length(leap, m);
    return total;
  endfunction

  // First day of year idx within a four-year set; the first year is leap.
  function automatic logic [31:0] year_offset(input logic [31:0] idx);
    return idx * 32'd365 + ((idx != 32'd0) ? 32'd1 : 32'd0);
  endfunction

  function automatic stamp_t seconds_to_calendar(input logic [31:0] gps_s);
    stamp_t r;
    logic [31:0] t, days, quad, rem, yi, mi;
    r = '0;
    t = gps_s + 32'd432000;
    r.sec = 6'(t % 32'd60);
    t = t / 32'd60;
    r.minute = 6'(t % 32'd60);
    t = t / 32'd60;
    r.hour = 5'(t % 32'd24);
    days = t / 32'd24;
    quad = days / 32'd1461;
    rem = days % 32'd1461;
    yi = 32'd0;
    while (yi < 32'd3 && rem >= year_offset(yi + 32'd1)) yi++;
    rem = rem - year_offset(yi);
    mi = 32'd0;
    while (mi < 32'd11 && rem >= month_offset(yi == 32'd0, mi + 32'd1)) mi++;
    r.year = 12'(32'd1980 + 32'd4 * quad + yi);
    r.month = 4'(mi + 32'd1);
    r.day = 5'(rem - month_offset(yi == 32'd0, mi) + 32'd1);
    // 1 Jan 1980 was a Tuesday
    r.weekday = 3'((days + 32'd1) % 32'd7);
    return r;
  endfunction

  function automatic logic [31:0] calendar_to_seconds(input logic [11:0] yr,
      input logic [3:0] mo, input logic [4:0] dy, input logic [4:0] hr,
      input logic [5:0] mn, input logic [5:0] sc);
    int sets;
    logic [31:0] t, yi, mi;
    // truncate toward zero, also for years before the epoch
    sets = (int'({20'd0, yr}) - 1980) / 4;
    t = 32'(sets * 1461);
    yi = {30'd0, yr[1:0]};
    mi = (mo == 4'd0) ? 32'd0 : {28'd0, mo} - 32'd1;
    if (mi > 32'd12) mi = 32'd12;
    if (yi == 32'd0) begin
      t = t + month_offset(1'b1, mi);
    end else begin
      t = t + year_offset(yi) + month_offset(1'b0, mi);
    end
    t = t + {27'd0, dy} - 32'd1;
    t = t * 32'd24 + {27'd0, hr};
    t = t * 32'd60 + {26'd0, mn};
    t = t * 32'd60 + {26'd0, sc};
    return t - 32'd432000;
  endfunction

  function automatic stamp_t predict_stamp(input logic cmd, input logic [71:0] d);
    stamp_t r;
    if (!cmd) begin
      r = seconds_to_calendar(d[31:0]);
    end else begin
      r = '0;
      r.seconds = calendar_to_seconds(d[43:32], d[47:44], d[52:48], d[57:53],
                                      d[63:58], d[69:64]);
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_tally++;
    end
  endtask

  always @(posedge clk) begin
    stamp_t want;
    if (!rst) begin
      // check the output beat first: it can never belong to this edge's input
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_stamps.size() == 0) begin
          $error("result beat with no conversion pending: %h", m_axis_tdata);
          mismatch_tally++;
        end else begin
          want = expected_stamps.pop_front();
          compare_field("out_seconds", want.seconds, m_axis_tdata[31:0]);
          compare_field("out_year", 32'(want.year), 32'(m_axis_tdata[43:32]));
          compare_field("out_month", 32'(want.month), 32'(m_axis_tdata[47:44]));
          compare_field("out_day", 32'(want.day), 32'(m_axis_tdata[52:48]));
          compare_field("out_hour", 32'(want.hour), 32'(m_axis_tdata[57:53]));
          compare_field("out_minute", 32'(want.minute), 32'(m_axis_tdata[63:58]));
          compare_field("out_sec", 32'(want.sec), 32'(m_axis_tdata[69:64]));
          compare_field("weekday", 32'(want.weekday), 32'(m_axis_tdata[72:70]));
          compare_field("padding", 32'd0, 32'(m_axis_tdata[79:73]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_stamps.push_back(predict_stamp(s_axis_tuser, s_axis_tdata));
    end
    error_count <= mismatch_tally;
    pending_count <= expected_stamps.size();
  end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;

  localparam int RANDOM_BEATS = 450;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  int error_count;
  int pending_count;
  int results_seen = 0;

  always #4 clk = ~clk;

  gps_seconds_calendar_convert_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gps_seconds_calendar_convert_checker conv_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Leave valid high on return so a burst runs back to back.
  task automatic send_beat(input logic cmd, input logic [31:0] secs,
      input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy,
      input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, sc, mn, hr, dy, mo, yr, secs};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random_beat();
    logic        cmd;
    logic [31:0] secs;
    logic [31:0] r;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy, hr;
    logic [5:0]  mn, sc;
    cmd = 1'($urandom_range(0, 1));
    r = $urandom;
    yr = r[11:0];
    mo = r[15:12];
    dy = r[20:16];
    hr = r[25:21];
    mn = r[31:26];
    sc = 6'($urandom);
    secs = $urandom;
    if (!cmd) begin
      case ($urandom_range(0, 9))
        0, 1:    secs = 32'hFFFF_FFFF - $urandom_range(0, 600000);
        2, 3:    secs = $urandom_range(0, 100000000);
        // land near midnight of a random day
        4, 5:    secs = 32'($urandom_range(0, 49700)) * 32'd86400 - 32'd432000
                        + 32'($urandom_range(0, 3)) - 32'd2;
        default: secs = $urandom;
      endcase
    end else if ($urandom_range(0, 4) != 0) begin
      // fields in range, though the day may pass the month's end; a few out-of-range ones pass through above
      yr = 12'($urandom_range(1980, 2116));
      mo = 4'($urandom_range(1, 12));
      dy = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(29, 31))
                                       : 5'($urandom_range(1, 28));
      hr = 5'($urandom_range(0, 23));
      mn = 6'($urandom_range(0, 59));
      sc = 6'($urandom_range(0, 59));
    end
    send_beat(cmd, secs, yr, mo, dy, hr, mn, sc);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
  end

  initial begin : receiver
    int seg_len, seg_mode, k, held;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      seg_len = $urandom_range(10, 60);
      seg_mode = $urandom_range(0, 2);
      for (k = 0; k < seg_len; k++) begin
        @(posedge clk);
        case (seg_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      // hold off long enough for the pipeline to fill and stall the input
      if (!hold_done && results_seen >= 80) begin
        @(posedge clk);
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_done = 1'b1;
      end
    end
  end

  initial begin : sender
    int sent, burst, gap;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // seconds to date: epoch, top of range, wrap of the epoch shift, leap day,
    // last day of a set, first day of the next set
    send_beat(1'b0, 32'd0, '0, '0, '0, '0, '0, '0);
    send_beat(1'b0, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
    send_beat(1'b0, 32'd4294535296, '0, '0, '0, '0, '0, '0);
    send_beat(1'b0, 32'd4294535295, '0, '0, '0, '0, '0, '0);
    send_beat(1'b0, 32'd4665600, '0, '0, '0, '0, '0, '0);
    send_beat(1'b0, 32'd1460 * 32'd86400 + 32'd86399 - 32'd432000, '0, '0, '0, '0,
              '0, '0);
    send_beat(1'b0, 32'd1461 * 32'd86400 - 32'd432000, '0, '0, '0, '0, '0, '0);
    // date fields are ignored in this direction
    send_beat(1'b0, 32'd123456789, 12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);

    // date to seconds
    send_beat(1'b1, 32'd0, 12'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'hFFFF_FFFF, 12'd1980, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'd2116, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_beat(1'b1, 32'd0, 12'd1979, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_beat(1'b1, 32'd0, 12'd1976, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'hFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
    send_beat(1'b1, 32'd0, 12'd2000, 4'd0, 5'd15, 5'd12, 6'd30, 6'd30);
    send_beat(1'b1, 32'd0, 12'd1984, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'd1985, 4'd14, 5'd1, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'd1987, 4'd15, 5'd2, 5'd1, 6'd2, 6'd3);
    send_beat(1'b1, 32'd0, 12'd1990, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'd2001, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'd0, 12'd1981, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0);
    send_beat(1'b1, 32'hFFFF_FFFF, 12'd2024, 4'd2, 5'd29, 5'd31, 6'd63, 6'd63);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
        send_random_beat();
        sent++;
        // drain completely once, midway
        if (sent == RANDOM_BEATS / 2) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4 * gsc_pkg::PIPE_DEPTH) @(posedge clk);

    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
